// ===== rtl/core/hgr_pkg.sv =====
// hgr_pkg: shared types, constants and step tables for the hex grid raster block
// no dependencies; imported by the interfaces and every rtl/core module
package hgr_pkg;

    // signed working coordinate: covers input range plus a hexagon radius
    localparam int COORD_W = 8;
    typedef logic signed [COORD_W-1:0] coord_t;

    // field widths fixed by the channel payloads
    localparam int POS_W    = 5;
    localparam int RADIUS_W = 4;
    localparam int COLOR_W  = 8;
    localparam int SIDE_W   = 3;

    // command kinds
    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_HEX  = 1'b1;

    // hexagon side indexes
    localparam logic [SIDE_W-1:0] SIDE_FIRST = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_LAST  = 3'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // latch a new drawing request
        logic emit;   // write the current cell to the output register and step
    } hgr_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_last; // current cell closes the drawing
    } hgr_status_t;

    // x step of each hexagon side
    function automatic coord_t hex_step_x(input logic [SIDE_W-1:0] side);
        coord_t step;
        case (side)
            3'd0:    step = 8'sd1;
            3'd1:    step = 8'sd0;
            3'd2:    step = -8'sd1;
            3'd3:    step = -8'sd1;
            3'd4:    step = 8'sd0;
            3'd5:    step = 8'sd1;
            default: step = 8'sd0;
        endcase
        return step;
    endfunction

    // y step of each hexagon side
    function automatic coord_t hex_step_y(input logic [SIDE_W-1:0] side);
        coord_t step;
        case (side)
            3'd0:    step = 8'sd0;
            3'd1:    step = -8'sd1;
            3'd2:    step = -8'sd1;
            3'd3:    step = 8'sd0;
            3'd4:    step = 8'sd1;
            3'd5:    step = 8'sd1;
            default: step = 8'sd0;
        endcase
        return step;
    endfunction

endpackage

// ===== rtl/core/hgr_if.sv =====
// hgr_cmd_if and hgr_pix_if: valid/ready channels for drawing requests and plotted cells
// depends on hgr_pkg
interface hgr_cmd_if;
    import hgr_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [POS_W-1:0]    start_x;
    logic [POS_W-1:0]    start_y;
    logic [POS_W-1:0]    end_x;
    logic [POS_W-1:0]    end_y;
    logic [RADIUS_W-1:0] radius;
    logic [COLOR_W-1:0]  color;

    modport source (output valid, kind, start_x, start_y, end_x, end_y, radius, color,
                    input ready);
    modport sink   (input valid, kind, start_x, start_y, end_x, end_y, radius, color,
                    output ready);
endinterface

interface hgr_pix_if;
    import hgr_pkg::*;

    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   cell_x;
    logic [POS_W-1:0]   cell_y;
    logic               off_grid;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;

    modport source (output valid, cell_x, cell_y, off_grid, pixel_color, last,
                    input ready);
    modport sink   (input valid, cell_x, cell_y, off_grid, pixel_color, last,
                    output ready);
endinterface

// ===== rtl/core/hgr_ctrl.sv =====
// hgr_ctrl: idle/run state machine and output valid flag of the raster block
// depends on hgr_pkg
module hgr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hgr_pkg::hgr_cmd_t    cmd,
    input  hgr_pkg::hgr_status_t status
);
    import hgr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    // handshake and datapath commands
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign cmd.load  = in_valid && in_ready;
    assign cmd.emit  = (state_reg == ST_RUN) && out_free;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.emit && status.is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/hgr_dp.sv =====
// hgr_dp: line stepper, hexagon walker and output register of the raster block
// depends on hgr_pkg
module hgr_dp #(
    parameter int GRID_SIZE  = 23,
    parameter int MAX_RADIUS = 10
) (
    input  logic                          clk,
    input  hgr_pkg::hgr_cmd_t             cmd,
    output hgr_pkg::hgr_status_t          status,
    input  logic                          kind,
    input  logic [hgr_pkg::POS_W-1:0]     start_x,
    input  logic [hgr_pkg::POS_W-1:0]     start_y,
    input  logic [hgr_pkg::POS_W-1:0]     end_x,
    input  logic [hgr_pkg::POS_W-1:0]     end_y,
    input  logic [hgr_pkg::RADIUS_W-1:0]  radius,
    input  logic [hgr_pkg::COLOR_W-1:0]   color,
    output logic [hgr_pkg::POS_W-1:0]     cell_x,
    output logic [hgr_pkg::POS_W-1:0]     cell_y,
    output logic                          off_grid,
    output logic [hgr_pkg::COLOR_W-1:0]   pixel_color,
    output logic                          last
);
    import hgr_pkg::*;

    localparam logic [RADIUS_W-1:0] RADIUS_CAP = RADIUS_W'(MAX_RADIUS);
    localparam coord_t              GRID_LIM   = COORD_W'(GRID_SIZE);

    // working state of the current drawing
    logic                kind_reg;
    coord_t              x_reg, y_reg;
    coord_t              x1_reg, y1_reg;
    coord_t              dx_reg, dy_reg, err_reg;
    logic                neg_x_reg, neg_y_reg;
    logic [RADIUS_W-1:0] r_reg;
    logic [SIDE_W-1:0]   side_reg;
    logic [RADIUS_W-1:0] step_reg;
    logic [COLOR_W-1:0]  color_reg;

    // output register
    logic [POS_W-1:0]    cell_x_reg, cell_y_reg;
    logic                off_reg, last_reg;
    logic [COLOR_W-1:0]  pix_color_reg;

    // load values
    coord_t              sx_c, sy_c, ex_c, ey_c;
    coord_t              diff_x, diff_y, abs_dx, abs_dy;
    logic [RADIUS_W-1:0] r_sat;

    // step values
    coord_t              e2;
    logic                step_x, step_y, side_end, cur_last, cur_off;
    coord_t              line_x_next, line_y_next, err_next;

    assign sx_c   = coord_t'({3'b000, start_x});
    assign sy_c   = coord_t'({3'b000, start_y});
    assign ex_c   = coord_t'({3'b000, end_x});
    assign ey_c   = coord_t'({3'b000, end_y});
    assign diff_x = ex_c - sx_c;
    assign diff_y = ey_c - sy_c;
    assign abs_dx = diff_x[COORD_W-1] ? -diff_x : diff_x;
    assign abs_dy = diff_y[COORD_W-1] ? -diff_y : diff_y;
    assign r_sat  = (radius > RADIUS_CAP) ? RADIUS_CAP : radius;

    // bresenham error step
    always_comb
    begin
        e2          = {err_reg[COORD_W-2:0], 1'b0};
        step_x      = (e2 >= dy_reg);
        step_y      = (e2 <= dx_reg);
        err_next    = err_reg + (step_x ? dy_reg : '0) + (step_y ? dx_reg : '0);
        line_x_next = x_reg;
        line_y_next = y_reg;
        if (step_x)
        begin
            line_x_next = neg_x_reg ? x_reg - 8'sd1 : x_reg + 8'sd1;
        end
        if (step_y)
        begin
            line_y_next = neg_y_reg ? y_reg - 8'sd1 : y_reg + 8'sd1;
        end
    end

    // last cell and grid bound checks
    assign side_end = (step_reg == r_reg - RADIUS_W'(1));
    assign cur_last = (kind_reg == KIND_LINE)
                    ? ((x_reg == x1_reg) && (y_reg == y1_reg))
                    : ((r_reg == '0) || ((side_reg == SIDE_LAST) && side_end));
    assign cur_off  = x_reg[COORD_W-1] || (x_reg >= GRID_LIM)
                   || y_reg[COORD_W-1] || (y_reg >= GRID_LIM);
    assign status.is_last = cur_last;

    // drawing state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            color_reg <= color;
            x1_reg    <= ex_c;
            y1_reg    <= ey_c;
            dx_reg    <= abs_dx;
            dy_reg    <= -abs_dy;
            err_reg   <= abs_dx - abs_dy;
            neg_x_reg <= !(start_x < end_x);
            neg_y_reg <= !(start_y < end_y);
            r_reg     <= r_sat;
            side_reg  <= SIDE_FIRST;
            step_reg  <= '0;
            x_reg     <= sx_c;
            if (kind == KIND_LINE)
            begin
                y_reg <= sy_c;
            end
            else
            begin
                y_reg <= sy_c + coord_t'({4'b0000, r_sat});
            end
        end
        else if (cmd.emit)
        begin
            if (kind_reg == KIND_LINE)
            begin
                x_reg   <= line_x_next;
                y_reg   <= line_y_next;
                err_reg <= err_next;
            end
            else
            begin
                x_reg <= x_reg + hex_step_x(side_reg);
                y_reg <= y_reg + hex_step_y(side_reg);
                if (side_end)
                begin
                    step_reg <= '0;
                    side_reg <= side_reg + SIDE_W'(1);
                end
                else
                begin
                    step_reg <= step_reg + RADIUS_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            cell_x_reg    <= cur_off ? '0 : x_reg[POS_W-1:0];
            cell_y_reg    <= cur_off ? '0 : y_reg[POS_W-1:0];
            off_reg       <= cur_off;
            last_reg      <= cur_last;
            pix_color_reg <= color_reg;
        end
    end

    assign cell_x      = cell_x_reg;
    assign cell_y      = cell_y_reg;
    assign off_grid    = off_reg;
    assign last        = last_reg;
    assign pixel_color = pix_color_reg;

endmodule

// ===== rtl/core/hex_grid_line_and_ring_raster.sv =====
// hex_grid_line_and_ring_raster: top level of the hex grid line and hexagon rasterizer
// depends on hgr_pkg, hgr_if, hgr_ctrl and hgr_dp
//
// Usage:
//   cmd carries one drawing request: a line between two points (kind 0) or a
//   hexagon outline of the given radius around a center (kind 1), plus a color.
//   pix returns one plotted cell per result, with off_grid set and the
//   coordinates zeroed for cells outside the GRID_SIZE square, and last set on
//   the closing cell of each request.
//   Timing: a request is taken while the block is idle; its first cell is written
//   to the output register and shows on pix from there, and further cells follow
//   one per cycle while pix is ready. A request holds the input off until its
//   final cell has been written to the output register. A line has at most 32
//   cells, a hexagon 6*radius (at most 60), radius 0 a single one. The single
//   cell stepper computes one cell per cycle while pix is ready.
//   The next request is taken as soon as the final cell sits in the output
//   register, even if pix has not yet taken it.
//   A stall on pix holds the current cell and pauses the stepper, no cell is
//   lost. Reset empties the output register and returns the block to idle.
module hex_grid_line_and_ring_raster #(
    parameter int GRID_SIZE  = 23,
    parameter int MAX_RADIUS = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    hgr_cmd_if.sink   cmd,
    hgr_pix_if.source pix
);
    import hgr_pkg::*;

    hgr_cmd_t    ctl_cmd;
    hgr_status_t dp_status;

    // request sequencing
    hgr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (pix.valid),
        .out_ready (pix.ready),
        .cmd       (ctl_cmd),
        .status    (dp_status)
    );

    // cell stepping and output register
    hgr_dp #(
        .GRID_SIZE  (GRID_SIZE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk         (clk),
        .cmd         (ctl_cmd),
        .status      (dp_status),
        .kind        (cmd.kind),
        .start_x     (cmd.start_x),
        .start_y     (cmd.start_y),
        .end_x       (cmd.end_x),
        .end_y       (cmd.end_y),
        .radius      (cmd.radius),
        .color       (cmd.color),
        .cell_x      (pix.cell_x),
        .cell_y      (pix.cell_y),
        .off_grid    (pix.off_grid),
        .pixel_color (pix.pixel_color),
        .last        (pix.last)
    );

endmodule

// ===== bench/hex_grid_line_and_ring_raster_tb.sv =====
// hex_grid_line_and_ring_raster_tb: self-checking bench for the hex grid line and ring raster
// predicts every plotted cell of each request and checks the pix channel in order
// depends on hgr_pkg, hgr_cmd_if, hgr_pix_if and hex_grid_line_and_ring_raster
module hex_grid_line_and_ring_raster_tb;
    import hgr_pkg::*;

    localparam int GRID         = 23;
    localparam int RADIUS_CAP   = 10;
    localparam int LINE_CAP     = 60;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_TICKS = 70;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic                kind;
        logic [POS_W-1:0]    start_x;
        logic [POS_W-1:0]    start_y;
        logic [POS_W-1:0]    end_x;
        logic [POS_W-1:0]    end_y;
        logic [RADIUS_W-1:0] radius;
        logic [COLOR_W-1:0]  color;
    } draw_req_t;

    typedef struct packed {
        logic [POS_W-1:0]   cell_x;
        logic [POS_W-1:0]   cell_y;
        logic               off_grid;
        logic [COLOR_W-1:0] color;
        logic               last;
    } plot_t;

    logic clk = 1'b0;
    logic rst_n;

    hgr_cmd_if cmd_bus();
    hgr_pix_if pix_bus();

    plot_t plot_queue[$];
    int    fail_count   = 0;
    int    cycle_count  = 0;
    bit    src_idle_on  = 1'b1;
    bit    sink_idle_on = 1'b1;
    bit    hold_request = 1'b0;
    int    hold_left    = 0;

    hex_grid_line_and_ring_raster #(
        .GRID_SIZE  (GRID),
        .MAX_RADIUS (RADIUS_CAP)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pix   (pix_bus)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // step of each ring side
    function automatic void ring_step(input int side, output int step_x, output int step_y);
        case (side)
            0:       begin step_x = 1;  step_y = 0;  end
            1:       begin step_x = 0;  step_y = -1; end
            2:       begin step_x = -1; step_y = -1; end
            3:       begin step_x = -1; step_y = 0;  end
            4:       begin step_x = 0;  step_y = 1;  end
            default: begin step_x = 1;  step_y = 1;  end
        endcase
    endfunction

    // queue one expected cell, zeroed and flagged when off the grid
    function automatic void add_plot(input int x, input int y, input logic [COLOR_W-1:0] color,
                                     input bit last);
        plot_t p;
        bit    off;
        off        = (x < 0) || (x >= GRID) || (y < 0) || (y >= GRID);
        p.cell_x   = off ? '0 : x[POS_W-1:0];
        p.cell_y   = off ? '0 : y[POS_W-1:0];
        p.off_grid = off;
        p.color    = color;
        p.last     = last;
        plot_queue.push_back(p);
    endfunction

    // expected cells of one request, in drawing order
    function automatic void rasterize_request(input draw_req_t req);
        int x, y, x1, y1, dx, dy, sx, sy, err, e2, r, n, side, i, step_x, step_y;
        bit done, stop;
        x  = int'(req.start_x);
        y  = int'(req.start_y);
        x1 = int'(req.end_x);
        y1 = int'(req.end_y);
        if (req.kind == KIND_LINE)
        begin
            // all-octant bresenham, both end cells plotted
            dx   = (x1 >= x) ? x1 - x : x - x1;
            dy   = (y1 >= y) ? y - y1 : y1 - y;
            sx   = (x < x1) ? 1 : -1;
            sy   = (y < y1) ? 1 : -1;
            err  = dx + dy;
            n    = 0;
            stop = 1'b0;
            while (!stop)
            begin
                done = (x == x1) && (y == y1);
                add_plot(x, y, req.color, done);
                n++;
                if (done || n >= LINE_CAP)
                    stop = 1'b1;
                else
                begin
                    e2 = 2 * err;
                    if (e2 >= dy)
                    begin
                        err += dy;
                        x   += sx;
                    end
                    if (e2 <= dx)
                    begin
                        err += dx;
                        y   += sy;
                    end
                end
            end
        end
        else
        begin
            // ring walk from the top cell, radius saturated
            r = int'(req.radius);
            if (r > RADIUS_CAP)
                r = RADIUS_CAP;
            if (r == 0)
                add_plot(x, y, req.color, 1'b1);
            else
            begin
                y += r;
                n  = 0;
                for (side = 0; side < 6; side++)
                begin
                    ring_step(side, step_x, step_y);
                    for (i = 0; i < r; i++)
                    begin
                        add_plot(x, y, req.color, n == 6 * r - 1);
                        n++;
                        x += step_x;
                        y += step_y;
                    end
                end
            end
        end
    endfunction

    function automatic void note_failure(input string what, input plot_t want, input plot_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0s at cycle %0d: expected x=%0d y=%0d off=%0b color=%0d last=%0b, got x=%0d y=%0d off=%0b color=%0d last=%0b",
                     what, cycle_count, want.cell_x, want.cell_y, want.off_grid, want.color,
                     want.last, got.cell_x, got.cell_y, got.off_grid, got.color, got.last);
    endfunction

    // compare one taken cell with the oldest expectation
    task automatic check_plot();
        plot_t want, got;
        got.cell_x   = pix_bus.cell_x;
        got.cell_y   = pix_bus.cell_y;
        got.off_grid = pix_bus.off_grid;
        got.color    = pix_bus.pixel_color;
        got.last     = pix_bus.last;
        if (plot_queue.size() == 0)
            note_failure("unexpected cell", '0, got);
        else
        begin
            want = plot_queue.pop_front();
            if ((got.cell_x !== want.cell_x) || (got.cell_y !== want.cell_y) ||
                (got.off_grid !== want.off_grid) || (got.color !== want.color) ||
                (got.last !== want.last))
                note_failure("cell mismatch", want, got);
        end
    endtask

    // cell sink: check, then pick next ready (random idle or long hold-off)
    always @(posedge clk)
    begin
        if (rst_n && pix_bus.valid && pix_bus.ready)
            check_plot();
        if (hold_left > 0)
        begin
            hold_left--;
            pix_bus.ready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            pix_bus.ready <= 1'b0;
        end
        else if (sink_idle_on)
            pix_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
        else
            pix_bus.ready <= 1'b1;
    end

    // offer one request and wait until it is taken
    task automatic send_request(input draw_req_t req);
        int gap;
        gap = 0;
        while (src_idle_on && ($urandom_range(99) < IDLE_PCT) && (gap < 24))
            gap++;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.kind    <= req.kind;
        cmd_bus.start_x <= req.start_x;
        cmd_bus.start_y <= req.start_y;
        cmd_bus.end_x   <= req.end_x;
        cmd_bus.end_y   <= req.end_y;
        cmd_bus.radius  <= req.radius;
        cmd_bus.color   <= req.color;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        rasterize_request(req);
    endtask

    // stop offering and wait for every expected cell
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (plot_queue.size() != 0)
            @(posedge clk);
    endtask

    function automatic draw_req_t make_req(input logic kind, input int sx, input int sy,
                                           input int ex, input int ey, input int r,
                                           input int color);
        draw_req_t req;
        req.kind    = kind;
        req.start_x = sx[POS_W-1:0];
        req.start_y = sy[POS_W-1:0];
        req.end_x   = ex[POS_W-1:0];
        req.end_y   = ey[POS_W-1:0];
        req.radius  = r[RADIUS_W-1:0];
        req.color   = color[COLOR_W-1:0];
        return req;
    endfunction

    // mostly on-grid points and legal radii, some full-range fields
    function automatic draw_req_t random_request();
        draw_req_t req;
        int        top;
        top         = ($urandom_range(99) < 80) ? GRID - 1 : (1 << POS_W) - 1;
        req.kind    = 1'($urandom_range(1));
        req.start_x = POS_W'($urandom_range(top));
        req.start_y = POS_W'($urandom_range(top));
        req.end_x   = POS_W'($urandom_range(top));
        req.end_y   = POS_W'($urandom_range(top));
        req.radius  = ($urandom_range(99) < 85)
                    ? RADIUS_W'($urandom_range(RADIUS_CAP))
                    : RADIUS_W'($urandom_range(15, RADIUS_CAP + 1));
        req.color   = COLOR_W'($urandom_range(255));
        return req;
    endfunction

    // extremes, every octant, degenerate line, off-grid cells, radius zero and saturation
    task automatic test_directed();
        send_request(make_req(KIND_LINE, 5, 5, 5, 5, 0, 0));
        send_request(make_req(KIND_LINE, 0, 0, 22, 0, 15, 255));
        send_request(make_req(KIND_LINE, 11, 11, 20, 14, 0, 1));
        send_request(make_req(KIND_LINE, 11, 11, 14, 20, 0, 2));
        send_request(make_req(KIND_LINE, 11, 11, 8, 20, 0, 4));
        send_request(make_req(KIND_LINE, 11, 11, 2, 14, 0, 8));
        send_request(make_req(KIND_LINE, 11, 11, 2, 8, 0, 16));
        send_request(make_req(KIND_LINE, 11, 11, 8, 2, 0, 32));
        send_request(make_req(KIND_LINE, 11, 11, 14, 2, 0, 64));
        send_request(make_req(KIND_LINE, 11, 11, 20, 8, 0, 128));
        send_request(make_req(KIND_LINE, 3, 0, 3, 22, 0, 85));
        send_request(make_req(KIND_LINE, 22, 22, 0, 0, 0, 170));
        send_request(make_req(KIND_LINE, 31, 31, 20, 25, 0, 200));
        send_request(make_req(KIND_LINE, 0, 31, 31, 0, 0, 255));
        send_request(make_req(KIND_HEX, 11, 11, 0, 0, 0, 7));
        send_request(make_req(KIND_HEX, 0, 0, 31, 31, 1, 9));
        send_request(make_req(KIND_HEX, 11, 11, 0, 0, 10, 255));
        send_request(make_req(KIND_HEX, 0, 0, 0, 0, 15, 0));
        send_request(make_req(KIND_HEX, 31, 31, 0, 0, 10, 170));
        send_request(make_req(KIND_HEX, 22, 22, 5, 5, 3, 85));
        send_request(make_req(KIND_HEX, 5, 17, 31, 31, 11, 99));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_request(random_request());
    endtask

    // sink holds off while requests keep coming, so the block stalls its input
    task automatic test_output_hold(input int count);
        hold_request = 1'b1;
        repeat (count) send_request(random_request());
    endtask

    // stretch with no idling on either side
    task automatic test_back_to_back(input int count);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (count) send_request(random_request());
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // sender pauses until all cells are out, then resumes
    task automatic test_drain_pause(input int count);
        repeat (count) send_request(random_request());
        wait_drained();
        repeat (count) send_request(random_request());
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.kind    = KIND_LINE;
        cmd_bus.start_x = '0;
        cmd_bus.start_y = '0;
        cmd_bus.end_x   = '0;
        cmd_bus.end_y   = '0;
        cmd_bus.radius  = '0;
        cmd_bus.color   = '0;
        pix_bus.ready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(300);
        test_output_hold(30);
        test_back_to_back(100);
        test_drain_pause(25);

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if ((fail_count == 0) && (plot_queue.size() == 0))
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== hex_grid_line_and_ring_raster.f =====
rtl/core/hgr_pkg.sv
rtl/core/hgr_if.sv
rtl/core/hgr_ctrl.sv
rtl/core/hgr_dp.sv
rtl/core/hex_grid_line_and_ring_raster.sv
bench/hex_grid_line_and_ring_raster_tb.sv
